/* rtl/hbdt_pkg.sv */
`timescale 1ns / 1ps

package hbdt_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_MOVE  = 2'd1,
    OP_STOP  = 2'd2,
    OP_SPEED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    DIR_STOP     = 3'd0,
    DIR_FWD      = 3'd1,
    DIR_BACK     = 3'd2,
    DIR_LEFT     = 3'd3,
    DIR_RIGHT    = 3'd4,
    DIR_PIV_L    = 3'd5,
    DIR_PIV_R    = 3'd6,
    DIR_STOP_ALT = 3'd7
  } dir_t;

  typedef enum logic [1:0] {
    POL_NONE = 2'd0,
    POL_FWD  = 2'd1,
    POL_REV  = 2'd2
  } pol_t;

  typedef enum logic [1:0] {
    CFG_DEAD_TIME  = 2'd0,
    CFG_TURN_DELTA = 2'd1,
    CFG_MIN_INNER  = 2'd2,
    CFG_FWD_TRIM   = 2'd3
  } cfg_idx_t;

  localparam logic [6:0] FULL_DUTY = 7'd100;
  localparam logic [7:0] WAIT_MAX  = 8'd255;

  localparam logic [3:0] PINS_OFF  = 4'h0;
  localparam logic [3:0] PINS_FWD  = 4'h5;
  localparam logic [3:0] PINS_BACK = 4'hA;
  localparam logic [3:0] PINS_PVL  = 4'h6;
  localparam logic [3:0] PINS_PVR  = 4'h9;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] direction;
    logic       custom_mode;
    logic [7:0] left_duty_req;
    logic [7:0] right_duty_req;
    logic [7:0] speed_req;
  } cmd_t;

  typedef struct packed {
    logic [3:0] bridge_pins;
    logic       pwm_on;
    logic [6:0] left_duty;
    logic [6:0] right_duty;
    logic [2:0] direction_now;
    logic       busy_res;
    logic [6:0] speed_now;
  } res_t;

  typedef struct packed {
    logic [7:0] dead_time_ticks;
    logic [6:0] turn_delta;
    logic [6:0] min_inner_speed;
    logic [6:0] forward_left_trim;
  } cfg_t;

  typedef struct packed {
    logic [6:0] speed_setting;
    logic [2:0] applied_direction;
    logic       applied_custom;
    logic       change_pending;
    logic [7:0] wait_count;
    logic [2:0] queued_direction;
    logic       queued_custom;
    logic [6:0] queued_left_duty;
    logic [6:0] queued_right_duty;
    logic [3:0] pin_state;
    logic [6:0] duty_left;
    logic [6:0] duty_right;
    logic       pwm_running;
  } state_t;

  typedef struct packed {
    logic       run;
    logic [6:0] left;
    logic [6:0] right;
  } duty_t;

  localparam cfg_t CFG_RESET = '{
    dead_time_ticks:   8'd30,
    turn_delta:        7'd5,
    min_inner_speed:   7'd55,
    forward_left_trim: 7'd4
  };

  localparam state_t ST_RESET = '{
    speed_setting:     7'd75,
    applied_direction: DIR_STOP,
    applied_custom:    1'b0,
    change_pending:    1'b0,
    wait_count:        8'd0,
    queued_direction:  DIR_STOP,
    queued_custom:     1'b0,
    queued_left_duty:  7'd0,
    queued_right_duty: 7'd0,
    pin_state:         PINS_OFF,
    duty_left:         7'd0,
    duty_right:        7'd0,
    pwm_running:       1'b0
  };

  function automatic logic [6:0] sat100(input logic [7:0] v);
    return (v > {1'b0, FULL_DUTY}) ? FULL_DUTY : v[6:0];
  endfunction

  function automatic pol_t left_pol(input logic [2:0] d);
    pol_t p;
    case (d)
      DIR_FWD, DIR_LEFT, DIR_RIGHT, DIR_PIV_R: p = POL_FWD;
      DIR_BACK, DIR_PIV_L:                     p = POL_REV;
      default:                                 p = POL_NONE;
    endcase
    return p;
  endfunction

  function automatic pol_t right_pol(input logic [2:0] d);
    pol_t p;
    case (d)
      DIR_FWD, DIR_LEFT, DIR_RIGHT, DIR_PIV_L: p = POL_FWD;
      DIR_BACK, DIR_PIV_R:                     p = POL_REV;
      default:                                 p = POL_NONE;
    endcase
    return p;
  endfunction

  function automatic logic needs_dead_time(input logic [2:0] cur, input logic [2:0] nxt);
    pol_t cl, nl, cr, nr;
    cl = left_pol(cur);
    nl = left_pol(nxt);
    cr = right_pol(cur);
    nr = right_pol(nxt);
    return ((cl != POL_NONE) && (nl != POL_NONE) && (cl != nl)) ||
           ((cr != POL_NONE) && (nr != POL_NONE) && (cr != nr));
  endfunction

  function automatic logic [3:0] pins_of(input logic [2:0] d);
    logic [3:0] p;
    case (d)
      DIR_FWD, DIR_LEFT, DIR_RIGHT: p = PINS_FWD;
      DIR_BACK:                     p = PINS_BACK;
      DIR_PIV_L:                    p = PINS_PVL;
      DIR_PIV_R:                    p = PINS_PVR;
      default:                      p = PINS_OFF;
    endcase
    return p;
  endfunction

endpackage

/* rtl/hbdt_cmd_if.sv */
`timescale 1ns / 1ps

interface hbdt_cmd_if import hbdt_pkg::*;;
  logic valid;
  logic ready;
  cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/hbdt_res_if.sv */
`timescale 1ns / 1ps

interface hbdt_res_if import hbdt_pkg::*;;
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/hbdt_cfg_regs.sv */
`timescale 1ns / 1ps

module hbdt_cfg_regs import hbdt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEAD_TIME:  cfg.dead_time_ticks   <= cfg_wdata;
        CFG_TURN_DELTA: cfg.turn_delta        <= cfg_wdata[6:0];
        CFG_MIN_INNER:  cfg.min_inner_speed   <= cfg_wdata[6:0];
        CFG_FWD_TRIM:   cfg.forward_left_trim <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/hbdt_step.sv */
`timescale 1ns / 1ps

module hbdt_step import hbdt_pkg::*; (
  input  state_t st,
  input  cfg_t   cfg,
  input  cmd_t   cmd,
  output state_t st_next
);

  // Manual duties for a direction at a given speed.
  function automatic duty_t manual_pwm(input logic [2:0] d, input logic [6:0] s,
                                       input cfg_t c);
    duty_t      r;
    logic [6:0] inner;
    logic [6:0] v;
    logic [6:0] fl;
    v     = (s > c.turn_delta) ? s - c.turn_delta : s;
    v     = (v < c.min_inner_speed) ? c.min_inner_speed : v;
    v     = (v > s) ? s : v;
    inner = (s <= c.min_inner_speed) ? s : v;
    fl    = (s > c.forward_left_trim) ? s - c.forward_left_trim : 7'd0;
    case (d)
      DIR_FWD:                        r = '{run: 1'b1, left: fl,    right: s};
      DIR_LEFT:                       r = '{run: 1'b1, left: inner, right: s};
      DIR_RIGHT:                      r = '{run: 1'b1, left: s,     right: inner};
      DIR_BACK, DIR_PIV_L, DIR_PIV_R: r = '{run: 1'b1, left: s,     right: s};
      default:                        r = '{run: 1'b0, left: 7'd0,  right: 7'd0};
    endcase
    return r;
  endfunction

  function automatic state_t apply_req(input state_t s, input logic [2:0] d,
                                       input logic custom, input logic [6:0] l,
                                       input logic [6:0] r, input cfg_t c);
    state_t o;
    duty_t  du;
    o  = s;
    du = custom ? duty_t'{run: 1'b1, left: sat100({1'b0, l}), right: sat100({1'b0, r})}
                : manual_pwm(d, s.speed_setting, c);
    o.pin_state         = pins_of(d);
    o.applied_direction = d;
    o.applied_custom    = custom;
    o.pwm_running       = du.run;
    o.duty_left         = du.left;
    o.duty_right        = du.right;
    return o;
  endfunction

  function automatic state_t do_stop(input state_t s);
    state_t o;
    o = s;
    o.change_pending    = 1'b0;
    o.queued_direction  = DIR_STOP;
    o.pwm_running       = 1'b0;
    o.duty_left         = 7'd0;
    o.duty_right        = 7'd0;
    o.pin_state         = PINS_OFF;
    o.applied_direction = DIR_STOP;
    o.applied_custom    = 1'b0;
    return o;
  endfunction

  logic [6:0] l_req;
  logic [6:0] r_req;
  logic [7:0] wc_inc;
  logic [6:0] new_speed;
  logic       stop_dir;
  duty_t      spd_duty;

  assign l_req     = cmd.custom_mode ? sat100(cmd.left_duty_req) : 7'd0;
  assign r_req     = cmd.custom_mode ? sat100(cmd.right_duty_req) : 7'd0;
  assign wc_inc    = (st.wait_count != WAIT_MAX) ? st.wait_count + 8'd1 : st.wait_count;
  assign new_speed = sat100(cmd.speed_req);
  assign stop_dir  = (cmd.direction == DIR_STOP) || (cmd.direction == DIR_STOP_ALT);
  assign spd_duty  = manual_pwm(st.applied_direction, new_speed, cfg);

  always_comb begin
    st_next = st;
    case (op_t'(cmd.op))
      OP_TICK: begin
        if (st.change_pending) begin
          st_next.wait_count = wc_inc;
          if (wc_inc >= cfg.dead_time_ticks) begin
            st_next.change_pending = 1'b0;
            st_next = apply_req(st_next, st.queued_direction, st.queued_custom,
                                st.queued_left_duty, st.queued_right_duty, cfg);
          end
        end
      end
      OP_MOVE: begin
        if (stop_dir) begin
          st_next = do_stop(st);
        end else if (st.change_pending) begin
          st_next.queued_direction  = cmd.direction;
          st_next.queued_custom     = cmd.custom_mode;
          st_next.queued_left_duty  = l_req;
          st_next.queued_right_duty = r_req;
        end else if ((st.applied_direction != DIR_STOP) &&
                     needs_dead_time(st.applied_direction, cmd.direction)) begin
          st_next.pwm_running       = 1'b0;
          st_next.duty_left         = 7'd0;
          st_next.duty_right        = 7'd0;
          st_next.pin_state         = PINS_OFF;
          st_next.applied_direction = DIR_STOP;
          st_next.queued_direction  = cmd.direction;
          st_next.queued_custom     = cmd.custom_mode;
          st_next.queued_left_duty  = l_req;
          st_next.queued_right_duty = r_req;
          st_next.wait_count        = 8'd0;
          st_next.change_pending    = 1'b1;
        end else begin
          st_next = apply_req(st, cmd.direction, cmd.custom_mode, l_req, r_req, cfg);
        end
      end
      OP_STOP: begin
        st_next = do_stop(st);
      end
      OP_SPEED: begin
        st_next.speed_setting = new_speed;
        if (!st.change_pending && (st.applied_direction != DIR_STOP) &&
            !st.applied_custom) begin
          st_next.pwm_running = spd_duty.run;
          st_next.duty_left   = spd_duty.left;
          st_next.duty_right  = spd_duty.right;
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

endmodule

/* rtl/hbridge_direction_deadtime_ctrl.sv */
`timescale 1ns / 1ps

// Dual H-bridge direction and duty controller.
// Channels: cmd (sink) takes one request per handshake: a 1 ms tick, a move,
// a stop or a speed change. res (source) gives exactly one result per
// request: bridge pins, PWM run flag, both duties, applied direction, the
// dead-time busy flag and the speed setting, all as they stand after that
// request. Configuration: cfg_we/cfg_index/cfg_wdata write dead time, turn
// delta, minimum inner speed and forward left trim; write only while idle.
// Path: input register, then one pass through the step logic into the state
// and result registers.
// Throughput: one request per cycle while res is ready; the state update is
// one short compare/subtract pass, so back-to-back requests never wait on it.
// Stall: when res is held off, the result register keeps its value and the
// input register still takes one more request; after that cmd.ready drops
// until the result drains.
// Reset (rst, synchronous): bridge off, PWM stopped, speed 75, nothing
// pending, configuration back to its defaults; no results are pending.
module hbridge_direction_deadtime_ctrl import hbdt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  hbdt_cmd_if.sink   cmd,
  hbdt_res_if.source res,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  logic   in_valid;
  cmd_t   in_item;
  logic   res_valid;
  res_t   res_item;
  logic   advance;
  logic   fire;

  hbdt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hbdt_step u_step (
    .st      (st),
    .cfg     (cfg),
    .cmd     (in_item),
    .st_next (st_next)
  );

  // Result slot frees up when empty or being taken this cycle.
  assign advance   = !res_valid || res.ready;
  assign fire      = in_valid && advance;
  assign cmd.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_item <= cmd.payload;
    end
  end

  // controller state commits when the request moves into the result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_item.bridge_pins   <= st_next.pin_state;
      res_item.pwm_on        <= st_next.pwm_running;
      res_item.left_duty     <= st_next.duty_left;
      res_item.right_duty    <= st_next.duty_right;
      res_item.direction_now <= st_next.applied_direction;
      res_item.busy_res      <= st_next.change_pending;
      res_item.speed_now     <= st_next.speed_setting;
    end
  end

  assign res.valid   = res_valid;
  assign res.payload = res_item;

endmodule

/* sim/hbridge_direction_deadtime_ctrl_tb.sv */
`timescale 1ns / 1ps

module hbridge_direction_deadtime_ctrl_tb;
  import hbdt_pkg::*;

  // Run limits. The cycle limit leaves a wide margin over the slowest legal run
  // (about 1900 requests, sender gaps, receiver stalls, one long hold-off,
  // dead-time tick runs).
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;     // extra wait after the last result
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int PHASE_GOAL    = 370;   // random requests per phase

  // Mirror of the controller: bridge pins, PWM, duties, dead-time wait.
  // Every accepted request yields one expected result, kept in order.
  class bridge_tracker;
    cfg_t       cfg;
    logic [6:0] speed;
    dir_t       cur_dir;
    logic       cur_custom;
    logic       waiting;
    logic [7:0] ticks_waited;
    dir_t       q_dir;
    logic       q_custom;
    logic [6:0] q_left;
    logic [6:0] q_right;
    logic [3:0] pins;
    logic [6:0] duty_l;
    logic [6:0] duty_r;
    logic       running;
    res_t       due_outputs[$];
    int         mismatches;

    function new();
      mismatches = 0;
      cfg.dead_time_ticks   = 8'd30;
      cfg.turn_delta        = 7'd5;
      cfg.min_inner_speed   = 7'd55;
      cfg.forward_left_trim = 7'd4;
      speed        = 7'd75;
      cur_dir      = DIR_STOP;
      cur_custom   = 1'b0;
      waiting      = 1'b0;
      ticks_waited = 8'd0;
      q_dir        = DIR_STOP;
      q_custom     = 1'b0;
      q_left       = 7'd0;
      q_right      = 7'd0;
      pins         = PINS_OFF;
      duty_l       = 7'd0;
      duty_r       = 7'd0;
      running      = 1'b0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [7:0] v);
      case (idx)
        CFG_DEAD_TIME:  cfg.dead_time_ticks   = v;
        CFG_TURN_DELTA: cfg.turn_delta        = v[6:0];
        CFG_MIN_INNER:  cfg.min_inner_speed   = v[6:0];
        CFG_FWD_TRIM:   cfg.forward_left_trim = v[6:0];
        default: ;
      endcase
    endfunction

    function logic [6:0] clamp_pct(logic [7:0] v);
      return (v > {1'b0, FULL_DUTY}) ? FULL_DUTY : v[6:0];
    endfunction

    // Drive polarity of one wheel; pivots spin the wheels opposite ways.
    function pol_t wheel_pol(dir_t d, bit right_wheel);
      case (d)
        DIR_FWD, DIR_LEFT, DIR_RIGHT: return POL_FWD;
        DIR_BACK:                     return POL_REV;
        DIR_PIV_L:                    return right_wheel ? POL_FWD : POL_REV;
        DIR_PIV_R:                    return right_wheel ? POL_REV : POL_FWD;
        default:                      return POL_NONE;
      endcase
    endfunction

    function bit reverses(dir_t a, dir_t b);
      pol_t pa;
      pol_t pb;
      for (int side = 0; side < 2; side++) begin
        pa = wheel_pol(a, side[0]);
        pb = wheel_pol(b, side[0]);
        if (pa != POL_NONE && pb != POL_NONE && pa != pb) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void pwm_idle();
      running = 1'b0;
      duty_l  = 7'd0;
      duty_r  = 7'd0;
    endfunction

    function void pwm_run(logic [6:0] l, logic [6:0] r);
      duty_l  = clamp_pct({1'b0, l});
      duty_r  = clamp_pct({1'b0, r});
      running = 1'b1;
    endfunction

    // Inner wheel in a manual turn: speed less delta, kept at or above the
    // minimum but capped at the speed; a delta not below the speed keeps the full speed.
    function logic [6:0] inner_wheel();
      int s;
      int v;
      s = speed;
      if (s <= cfg.min_inner_speed) return speed;
      v = (s > cfg.turn_delta) ? s - cfg.turn_delta : s;
      if (v < cfg.min_inner_speed) v = cfg.min_inner_speed;
      if (v > s) v = s;
      return v[6:0];
    endfunction

    function void manual_duties();
      case (cur_dir)
        DIR_FWD:
          pwm_run((speed > cfg.forward_left_trim) ? speed - cfg.forward_left_trim : 7'd0,
                  speed);
        DIR_LEFT:                      pwm_run(inner_wheel(), speed);
        DIR_RIGHT:                     pwm_run(speed, inner_wheel());
        DIR_BACK, DIR_PIV_L, DIR_PIV_R: pwm_run(speed, speed);
        default:                       pwm_idle();
      endcase
    endfunction

    function void drive_pins(dir_t d);
      case (d)
        DIR_FWD, DIR_LEFT, DIR_RIGHT: pins = PINS_FWD;
        DIR_BACK:                     pins = PINS_BACK;
        DIR_PIV_L:                    pins = PINS_PVL;
        DIR_PIV_R:                    pins = PINS_PVR;
        default: begin
          pins = PINS_OFF;
          pwm_idle();
        end
      endcase
    endfunction

    function void engage(dir_t d, logic custom, logic [6:0] l, logic [6:0] r);
      drive_pins(d);
      cur_dir    = d;
      cur_custom = custom;
      if (!custom) manual_duties();
      else pwm_run(l, r);
    endfunction

    function void halt();
      waiting    = 1'b0;
      q_dir      = DIR_STOP;
      pwm_idle();
      pins       = PINS_OFF;
      cur_dir    = DIR_STOP;
      cur_custom = 1'b0;
    endfunction

    function void hold_move(dir_t d, logic custom, logic [6:0] l, logic [6:0] r);
      q_dir    = d;
      q_custom = custom;
      q_left   = l;
      q_right  = r;
    endfunction

    // Bridge state after one request.
    function res_t advance(cmd_t c);
      res_t       o;
      dir_t       d;
      logic [6:0] l;
      logic [6:0] r;
      d = dir_t'(c.direction);
      l = c.custom_mode ? clamp_pct(c.left_duty_req) : 7'd0;
      r = c.custom_mode ? clamp_pct(c.right_duty_req) : 7'd0;
      case (op_t'(c.op))
        OP_TICK: begin
          if (waiting) begin
            if (ticks_waited != WAIT_MAX) ticks_waited++;
            if (ticks_waited >= cfg.dead_time_ticks) begin
              waiting = 1'b0;
              engage(q_dir, q_custom, q_left, q_right);
            end
          end
        end
        OP_MOVE: begin
          if (d == DIR_STOP || d == DIR_STOP_ALT) begin
            halt();
          end else if (waiting) begin
            hold_move(d, c.custom_mode, l, r);
          end else if (cur_dir != DIR_STOP && reverses(cur_dir, d)) begin
            // bridge off, request parked until the dead time has passed
            pwm_idle();
            pins    = PINS_OFF;
            cur_dir = DIR_STOP;
            hold_move(d, c.custom_mode, l, r);
            ticks_waited = 8'd0;
            waiting      = 1'b1;
          end else begin
            engage(d, c.custom_mode, l, r);
          end
        end
        OP_STOP: halt();
        default: begin
          speed = clamp_pct(c.speed_req);
          if (!waiting && cur_dir != DIR_STOP && !cur_custom) manual_duties();
        end
      endcase
      o.bridge_pins   = pins;
      o.pwm_on        = running;
      o.left_duty     = duty_l;
      o.right_duty    = duty_r;
      o.direction_now = cur_dir;
      o.busy_res      = waiting;
      o.speed_now     = speed;
      return o;
    endfunction

    function void take_request(cmd_t c);
      due_outputs.push_back(advance(c));
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(res_t got);
      res_t want;
      if (due_outputs.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        mismatches++;
        return;
      end
      want = due_outputs.pop_front();
      check_field("bridge_pins",   want.bridge_pins,   got.bridge_pins);
      check_field("pwm_on",        want.pwm_on,        got.pwm_on);
      check_field("left_duty",     want.left_duty,     got.left_duty);
      check_field("right_duty",    want.right_duty,    got.right_duty);
      check_field("direction_now", want.direction_now, got.direction_now);
      check_field("busy_res",      want.busy_res,      got.busy_res);
      check_field("speed_now",     want.speed_now,     got.speed_now);
    endfunction

    function int outstanding();
      return due_outputs.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  hbdt_cmd_if cmd ();
  hbdt_res_if res ();

  hbridge_direction_deadtime_ctrl dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bridge_tracker tracker;
  cmd_t          stim_q[$];
  bit            long_hold;
  int            cycle_count;
  cfg_t          phase_cfg[5];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result monitor: every accepted result is compared with the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) tracker.match_result(res.payload);
  end

  // Receiver: segments of always-ready, dense and sparse random stalls and
  // a fixed one-in-three pattern. On request it holds off for a long
  // stretch so the block fills up and backs up the command side.
  initial begin
    int seg;
    int mode;
    res.ready <= 1'b0;
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          res.ready <= 1'b0;
        end
      end
      seg  = $urandom_range(10, 120);
      mode = $urandom_range(0, 3);
      for (int k = 0; k < seg; k++) begin
        @(negedge clk);
        case (mode)
          0:       res.ready <= 1'b1;
          1:       res.ready <= ($urandom_range(0, 9) < 7);
          2:       res.ready <= ($urandom_range(0, 9) < 3);
          default: res.ready <= (k % 3 == 0);
        endcase
      end
    end
  end

  function automatic cmd_t mk(op_t op, dir_t d, bit custom, logic [7:0] l, logic [7:0] r,
                              logic [7:0] spd);
    cmd_t c;
    c.op             = op;
    c.direction      = d;
    c.custom_mode    = custom;
    c.left_duty_req  = l;
    c.right_duty_req = r;
    c.speed_req      = spd;
    return c;
  endfunction

  // Byte biased toward the clamp boundary and the extremes.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd100;
      3:       return 8'd101;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly real moves, now and then one of the two stop codes.
  function automatic dir_t rand_dir();
    case ($urandom_range(0, 19))
      0:       return DIR_STOP;
      1:       return DIR_STOP_ALT;
      default: return dir_t'($urandom_range(DIR_FWD, DIR_PIV_R));
    endcase
  endfunction

  // Random phase: moves, stops and speed changes mixed with single ticks and runs
  // of ticks that can outlast the dead time, plus some raw noise.
  function automatic void plan_random(int goal, cfg_t c);
    int made;
    int pick;
    int run;
    int dead;
    made = 0;
    dead = c.dead_time_ticks;
    while (made < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        stim_q.push_back(mk(OP_TICK, rand_dir(), 1'($urandom_range(0, 1)), rand_byte(),
                            rand_byte(), rand_byte()));
        made++;
      end else if (pick < 45) begin
        run = (dead > 40 && $urandom_range(0, 3) != 0) ? 40 : dead + 2;
        run = $urandom_range(1, run);
        repeat (run) stim_q.push_back(mk(OP_TICK, DIR_STOP, 1'b0, 8'd0, 8'd0, 8'd0));
        made += run;
      end else if (pick < 75) begin
        stim_q.push_back(mk(OP_MOVE, rand_dir(), 1'($urandom_range(0, 1)), rand_byte(),
                            rand_byte(), rand_byte()));
        made++;
      end else if (pick < 87) begin
        stim_q.push_back(mk(OP_SPEED, rand_dir(), 1'($urandom_range(0, 1)), rand_byte(),
                            rand_byte(), rand_byte()));
        made++;
      end else if (pick < 92) begin
        stim_q.push_back(mk(OP_STOP, rand_dir(), 1'($urandom_range(0, 1)), rand_byte(),
                            rand_byte(), rand_byte()));
        made++;
      end else begin
        stim_q.push_back(cmd_t'(30'($urandom)));
        made++;
      end
    end
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7:       return $urandom_range(1, 3);
      8:             return $urandom_range(4, 10);
      default:       return $urandom_range(10, 30);
    endcase
  endfunction

  // Sender: bursts of back-to-back requests with random gaps between them.
  // valid stays high across a burst; each request is noted on acceptance.
  task automatic send_all();
    cmd_t c;
    int   burst;
    int   gap;
    burst = 0;
    while (stim_q.size() != 0) begin
      c = stim_q.pop_front();
      if (burst == 0) begin
        gap = pick_gap();
        if (gap > 0) begin
          cmd.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 24);
      end
      cmd.valid   <= 1'b1;
      cmd.payload <= c;
      do @(posedge clk); while (!cmd.ready);
      tracker.take_request(c);
      burst--;
      @(negedge clk);
    end
    cmd.valid <= 1'b0;
  endtask

  task automatic settle();
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    tracker.set_reg(idx, v);
    @(negedge clk);
  endtask

  // Config is only touched with the block idle; we drops after the last write.
  task automatic load_config(cfg_t c);
    put_reg(CFG_DEAD_TIME, c.dead_time_ticks);
    put_reg(CFG_TURN_DELTA, {1'b0, c.turn_delta});
    put_reg(CFG_MIN_INNER, {1'b0, c.min_inner_speed});
    put_reg(CFG_FWD_TRIM, {1'b0, c.forward_left_trim});
    cfg_we <= 1'b0;
  endtask

  initial begin
    cfg_t cfg_b;
    cmd.valid   <= 1'b0;
    cmd.payload <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_DEAD_TIME;
    cfg_wdata   <= 8'd0;
    rst         <= 1'b1;
    cycle_count  = 0;
    long_hold    = 1'b0;
    tracker      = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset configuration (dead time 30, delta 5, min 55, trim 4).
    stim_q.push_back(mk(OP_TICK, DIR_STOP_ALT, 1'b1, 8'd255, 8'd255, 8'd255)); // idle tick
    stim_q.push_back(mk(OP_SPEED, DIR_STOP, 1'b0, 8'd0, 8'd0, 8'd255)); // clamp, stopped
    stim_q.push_back(mk(OP_MOVE, DIR_FWD, 1'b0, 8'd0, 8'd0, 8'd0));     // left trimmed
    stim_q.push_back(mk(OP_SPEED, DIR_STOP, 1'b0, 8'd0, 8'd0, 8'd0));   // speed zero live
    stim_q.push_back(mk(OP_SPEED, DIR_STOP, 1'b0, 8'd0, 8'd0, 8'd60));
    stim_q.push_back(mk(OP_MOVE, DIR_LEFT, 1'b0, 8'd0, 8'd0, 8'd0));    // inner at minimum
    stim_q.push_back(mk(OP_MOVE, DIR_RIGHT, 1'b1, 8'd255, 8'd0, 8'd0)); // custom, saturate
    stim_q.push_back(mk(OP_SPEED, DIR_STOP, 1'b0, 8'd0, 8'd0, 8'd90));  // custom: not applied
    stim_q.push_back(mk(OP_MOVE, DIR_STOP_ALT, 1'b0, 8'd0, 8'd0, 8'd0)); // code 7 stops
    stim_q.push_back(mk(OP_MOVE, DIR_FWD, 1'b1, 8'd100, 8'd101, 8'd0));
    stim_q.push_back(mk(OP_STOP, DIR_FWD, 1'b1, 8'd0, 8'd0, 8'd0));
    stim_q.push_back(mk(OP_MOVE, DIR_PIV_R, 1'b0, 8'd0, 8'd0, 8'd0));
    stim_q.push_back(mk(OP_MOVE, DIR_STOP, 1'b1, 8'd50, 8'd50, 8'd0));
    send_all();
    settle();

    // Directed, short dead time and a turn delta above the speed.
    cfg_b.dead_time_ticks   = 8'd2;
    cfg_b.turn_delta        = 7'd100;
    cfg_b.min_inner_speed   = 7'd0;
    cfg_b.forward_left_trim = 7'd100;
    load_config(cfg_b);
    stim_q.push_back(mk(OP_SPEED, DIR_STOP, 1'b0, 8'd0, 8'd0, 8'd50));
    stim_q.push_back(mk(OP_MOVE, DIR_LEFT, 1'b0, 8'd0, 8'd0, 8'd0));     // inner keeps 50
    stim_q.push_back(mk(OP_MOVE, DIR_FWD, 1'b0, 8'd0, 8'd0, 8'd0));      // trim floors at 0
    stim_q.push_back(mk(OP_MOVE, DIR_BACK, 1'b1, 8'd200, 8'd50, 8'd0));  // reversal, parked
    stim_q.push_back(mk(OP_SPEED, DIR_STOP, 1'b0, 8'd0, 8'd0, 8'd20));   // waiting: no duty
    stim_q.push_back(mk(OP_MOVE, DIR_PIV_L, 1'b0, 8'd0, 8'd0, 8'd0));    // replaces parked
    stim_q.push_back(mk(OP_TICK, DIR_STOP, 1'b0, 8'd0, 8'd0, 8'd0));
    stim_q.push_back(mk(OP_TICK, DIR_STOP, 1'b0, 8'd0, 8'd0, 8'd0));     // pivot applied
    stim_q.push_back(mk(OP_MOVE, DIR_PIV_R, 1'b1, 8'd7, 8'd99, 8'd0));   // both wheels flip
    stim_q.push_back(mk(OP_STOP, DIR_STOP, 1'b0, 8'd0, 8'd0, 8'd0));     // drops parked move
    stim_q.push_back(mk(OP_TICK, DIR_STOP, 1'b0, 8'd0, 8'd0, 8'd0));
    stim_q.push_back(mk(OP_MOVE, DIR_STOP, 1'b0, 8'd0, 8'd0, 8'd0));
    send_all();
    settle();

    // Random phases: all-minimum (zero dead time applies on the first tick),
    // all-maximum, reset values written back, then two random settings.
    phase_cfg[0] = '{8'd0, 7'd0, 7'd0, 7'd0};
    phase_cfg[1] = '{8'd255, 7'd100, 7'd100, 7'd100};
    phase_cfg[2] = '{8'd30, 7'd5, 7'd55, 7'd4};
    for (int p = 3; p < 5; p++) begin
      phase_cfg[p].dead_time_ticks   = 8'($urandom_range(1, 10));
      phase_cfg[p].turn_delta        = 7'($urandom_range(0, 100));
      phase_cfg[p].min_inner_speed   = 7'($urandom_range(0, 100));
      phase_cfg[p].forward_left_trim = 7'($urandom_range(0, 100));
    end
    for (int p = 0; p < 5; p++) begin
      load_config(phase_cfg[p]);
      if (p == 3) long_hold = 1'b1;
      plan_random(PHASE_GOAL, phase_cfg[p]);
      send_all();
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/hbdt_pkg.sv
rtl/hbdt_cmd_if.sv
rtl/hbdt_res_if.sv
rtl/hbdt_cfg_regs.sv
rtl/hbdt_step.sv
rtl/hbridge_direction_deadtime_ctrl.sv
sim/hbridge_direction_deadtime_ctrl_tb.sv
